// File: sv/tftp_read_transfer_sender_assert.svh
// Assertion macros shared by the TFTP read sender checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef TFTP_READ_TRANSFER_SENDER_ASSERT_SVH
`define TFTP_READ_TRANSFER_SENDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TRTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/trts_pkg.sv
// Types, constants and helper functions for the TFTP read transfer sender.
// No dependencies; used by trts_step, the top level and the checker.
`timescale 1ns / 1ps

package trts_pkg;

  localparam int BLOCK_BYTES = 512;

  localparam int OP_W    = 2;
  localparam int BLK_W   = 16;
  localparam int OFF_W   = 25;
  localparam int LEN_W   = 10;
  localparam int RETRY_W = 8;
  localparam int TICK_W  = 16;
  localparam int PHASE_W = 2;
  localparam int KIND_W  = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 25;

  // input item kinds
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_ACK   = 2'd2;

  // packet kinds
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  // phase codes as reported on the result
  localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_WAIT = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_DONE = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_FAIL = 2'd3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FILE_SIZE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_RETRIES   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST   = 8'd5;
  localparam logic [TICK_W-1:0]  TIMEOUT_TICKS_RST = 16'd5;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_DONE = 4'b0100,
    PH_FAIL = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [OFF_W-1:0]   file_size;
    logic [RETRY_W-1:0] max_retries;
    logic [TICK_W-1:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [BLK_W-1:0]   cur_block;
    logic [BLK_W-1:0]   acked_block;
    logic [LEN_W-1:0]   cur_len;
    logic [RETRY_W-1:0] retry_cnt;
    logic [TICK_W-1:0]  ticks;
    phase_t             phase;
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]  send_kind;
    logic [BLK_W-1:0]   block_number;
    logic [OFF_W-1:0]   byte_offset;
    logic [LEN_W-1:0]   payload_len;
    logic               retransmit;
    logic               ack_matched;
    logic [PHASE_W-1:0] phase;
  } result_t;

  // file offset of a block: ((blk - 1) mod 2^16) * BLOCK_BYTES, kept to OFF_W bits
  function automatic logic [OFF_W-1:0] blk_offset(input logic [BLK_W-1:0] blk);
    logic [BLK_W-1:0] idx;
    logic [31:0]      prod;
    idx  = blk - BLK_W'(1);
    prod = 32'(idx) * 32'(BLOCK_BYTES);
    return prod[OFF_W-1:0];
  endfunction

  // payload length given a block offset: BLOCK_BYTES, the remainder, or zero past the end of the file
  function automatic logic [LEN_W-1:0] blk_len(input logic [OFF_W-1:0] off,
                                               input logic [OFF_W-1:0] fsize);
    logic [OFF_W-1:0] rem;
    rem = fsize - off;
    if (fsize <= off) return '0;
    else if (rem < OFF_W'(BLOCK_BYTES)) return rem[LEN_W-1:0];
    else return LEN_W'(BLOCK_BYTES);
  endfunction

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
    logic [PHASE_W-1:0] code;
    unique case (ph)
      PH_IDLE: code = PHASE_IDLE;
      PH_WAIT: code = PHASE_WAIT;
      PH_DONE: code = PHASE_DONE;
      PH_FAIL: code = PHASE_FAIL;
      default: code = PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// File: sv/trts_step.sv
// Next-state and result logic for one event of the TFTP read sender.
// Depends on trts_pkg.
`timescale 1ns / 1ps

module trts_step (
  input  trts_pkg::cfg_t                cfg,
  input  trts_pkg::state_t              st,
  input  logic [trts_pkg::OP_W-1:0]     op,
  input  logic                          open_ok,
  input  logic [trts_pkg::BLK_W-1:0]    ack_block,
  output trts_pkg::state_t              st_nxt,
  output trts_pkg::result_t             res
);

  logic [trts_pkg::BLK_W-1:0]  new_blk;
  logic [trts_pkg::OFF_W-1:0]  new_off;
  logic [trts_pkg::LEN_W-1:0]  new_len;
  logic [trts_pkg::OFF_W-1:0]  cur_off;
  logic [trts_pkg::TICK_W-1:0] ticks_inc;
  logic                        in_wait;

  assign in_wait   = (st.phase == trts_pkg::PH_WAIT);
  assign new_blk   = (op == trts_pkg::OP_START) ? trts_pkg::BLK_W'(1)
                                                : st.cur_block + trts_pkg::BLK_W'(1);
  assign new_off   = trts_pkg::blk_offset(new_blk);
  assign new_len   = trts_pkg::blk_len(new_off, cfg.file_size);
  assign cur_off   = trts_pkg::blk_offset(st.cur_block);
  assign ticks_inc = (st.ticks != '1) ? st.ticks + trts_pkg::TICK_W'(1) : st.ticks;

  always_comb begin
    st_nxt = st;
    res    = '0;
    unique case (op)
      trts_pkg::OP_START: begin
        if (st.phase == trts_pkg::PH_IDLE) begin
          if (!open_ok) begin
            res.send_kind = trts_pkg::KIND_ERROR;
            st_nxt.phase  = trts_pkg::PH_FAIL;
          end else begin
            st_nxt.acked_block = '0;
            st_nxt.cur_block   = new_blk;
            st_nxt.cur_len     = new_len;
            st_nxt.retry_cnt   = '0;
            st_nxt.ticks       = '0;
            st_nxt.phase       = trts_pkg::PH_WAIT;
            res.send_kind      = trts_pkg::KIND_DATA;
            res.block_number   = new_blk;
            res.byte_offset    = new_off;
            res.payload_len    = new_len;
          end
        end
      end
      trts_pkg::OP_ACK: begin
        if (in_wait) begin
          st_nxt.retry_cnt = '0;
          if (ack_block == st.cur_block) begin
            st_nxt.acked_block = ack_block;
            res.ack_matched    = 1'b1;
          end
        end
      end
      trts_pkg::OP_TICK: begin
        if (in_wait) begin
          st_nxt.ticks = ticks_inc;
          priority if (st.retry_cnt >= cfg.max_retries) begin
            st_nxt.phase = trts_pkg::PH_FAIL;
          end else if (st.acked_block == st.cur_block) begin
            if (st.cur_len < trts_pkg::LEN_W'(trts_pkg::BLOCK_BYTES)) begin
              st_nxt.phase = trts_pkg::PH_DONE;
            end else begin
              st_nxt.cur_block = new_blk;
              st_nxt.cur_len   = new_len;
              st_nxt.retry_cnt = '0;
              st_nxt.ticks     = '0;
              res.send_kind    = trts_pkg::KIND_DATA;
              res.block_number = new_blk;
              res.byte_offset  = new_off;
              res.payload_len  = new_len;
            end
          end else if (ticks_inc >= cfg.timeout_ticks) begin
            if (st.retry_cnt != '1) st_nxt.retry_cnt = st.retry_cnt + trts_pkg::RETRY_W'(1);
            st_nxt.ticks     = '0;
            res.send_kind    = trts_pkg::KIND_DATA;
            res.block_number = st.cur_block;
            res.byte_offset  = cur_off;
            res.payload_len  = st.cur_len;
            res.retransmit   = 1'b1;
          end else begin
            st_nxt.ticks = ticks_inc;
          end
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
    res.phase = trts_pkg::phase_code(st_nxt.phase);
  end

endmodule

// File: sv/tftp_read_transfer_sender.sv
// The result of an accepted input transfer is registered in the output register.
// Throughput: 1 transfer per cycle; in_tready stays high while the output register is
// empty or being drained, so input and output overlap with no bubble.
// Reset (rst_n low, synchronous): phase idle, all counters zero, config registers to
// file_size 0, max_retries 5, timeout_ticks 5, output register empty.
// Depends on trts_pkg and trts_step.
`timescale 1ns / 1ps

module tftp_read_transfer_sender (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic                                 cfg_we,
  input  logic [trts_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [trts_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // event input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [0] open_ok, [16:1] ack_block, [23:17] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  // packet result
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] block_number, [40:16] byte_offset,
                                  // [50:41] payload_len, [51] retransmit,
                                  // [52] ack_matched, [54:53] phase, [55] zero
  output logic [1:0]  out_tuser   // [1:0] send_kind
);

  trts_pkg::cfg_t    cfg_r;
  trts_pkg::state_t  st_r;
  trts_pkg::state_t  st_nxt;
  trts_pkg::result_t res_nxt;
  trts_pkg::result_t res_r;
  logic              out_valid_r;
  logic              in_xfer;

  // Output register is the only buffer: take a new transfer whenever it is free
  // or being taken this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // Config registers; the user must write them only while the block is quiet, the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.file_size     <= '0;
      cfg_r.max_retries   <= trts_pkg::MAX_RETRIES_RST;
      cfg_r.timeout_ticks <= trts_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        trts_pkg::REG_FILE_SIZE:     cfg_r.file_size     <= cfg_wdata;
        trts_pkg::REG_MAX_RETRIES:   cfg_r.max_retries   <= cfg_wdata[trts_pkg::RETRY_W-1:0];
        trts_pkg::REG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_wdata[trts_pkg::TICK_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // All event handling is combinational off the state register.
  trts_step u_step (
    .cfg       (cfg_r),
    .st        (st_r),
    .op        (in_tuser),
    .open_ok   (in_tdata[0]),
    .ack_block (in_tdata[16:1]),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  // Transfer state advances once per accepted input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.cur_block   <= '0;
      st_r.acked_block <= '0;
      st_r.cur_len     <= '0;
      st_r.retry_cnt   <= '0;
      st_r.ticks       <= '0;
      st_r.phase       <= trts_pkg::PH_IDLE;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // Output register: every event yields exactly one result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.send_kind;
  assign out_tdata  = {1'b0, res_r.phase, res_r.ack_matched, res_r.retransmit,
                       res_r.payload_len, res_r.byte_offset, res_r.block_number};

endmodule

// File: sv/trts_checker.sv
// Port-level checks for tftp_read_transfer_sender, bound to the top level.
// Depends on trts_pkg and tftp_read_transfer_sender_assert.svh.
`timescale 1ns / 1ps
`include "tftp_read_transfer_sender_assert.svh"

module trts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser
);

  logic [1:0] out_phase;
  assign out_phase = out_tdata[54:53];

  // a stalled result must hold
  `TRTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  // an empty output register never blocks the input
  `TRTS_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready, "input stalled with empty output")
  // packet fields are zero unless a data block is sent
  `TRTS_ASSERT_NOW(a_no_data_zero, clk, rst_n, out_tvalid && out_tuser != trts_pkg::KIND_DATA, out_tdata[51:0] == '0, "packet fields set without data")
  // a data block leaves the transfer waiting for its ack
  `TRTS_ASSERT_NOW(a_data_waits, clk, rst_n, out_tvalid && out_tuser == trts_pkg::KIND_DATA, out_phase == trts_pkg::PHASE_WAIT, "data sent outside wait phase")
  // an error packet fails the transfer
  `TRTS_ASSERT_NOW(a_error_fails, clk, rst_n, out_tvalid && out_tuser == trts_pkg::KIND_ERROR, out_phase == trts_pkg::PHASE_FAIL, "error packet without failure")

endmodule

bind tftp_read_transfer_sender trts_checker u_trts_checker (.*);

// File: dv/tftp_read_transfer_sender_tb.sv
// Self-checking testbench for the TFTP read transfer sender: one transfer per run,
// driven through directed and randomized event streams. Depends on trts_pkg and the RTL.
`timescale 1ns / 1ps

module tftp_read_transfer_sender_tb;
  import trts_pkg::*;

  // reserved op code, must be ignored by the block
  localparam logic [OP_W-1:0] OP_RSVD = 2'd3;
  localparam logic [CFG_DATA_W-1:0] FILE_SIZE_MAX = 25'd33553919;
  localparam int STALL_LIMIT = 1000;   // cycles with no transfer on either side
  localparam int RANDOM_PHASES = 6;
  localparam int EVENTS_PER_PHASE = 62;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             open_ok;
    logic [BLK_W-1:0] ack_block;
  } sender_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [0] open_ok, [16:1] ack_block, [23:17] zero
  logic [1:0]  in_tuser = '0;   // [1:0] op

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // [15:0] block_number, [40:16] byte_offset,
                                // [50:41] payload_len, [51] retransmit,
                                // [52] ack_matched, [54:53] phase, [55] zero
  logic [1:0]  out_tuser;       // [1:0] send_kind

  always #1 clk = ~clk;

  tftp_read_transfer_sender dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // ---------------------------------------------------------------------------
  // Sender predictor: mirrors of the config registers and the transfer state.
  // ---------------------------------------------------------------------------
  logic [OFF_W-1:0]   fsize_cfg   = '0;
  logic [RETRY_W-1:0] retry_limit = MAX_RETRIES_RST;
  logic [TICK_W-1:0]  tick_limit  = TIMEOUT_TICKS_RST;

  logic [BLK_W-1:0]   cur_blk   = '0;
  logic [BLK_W-1:0]   acked_blk = '0;
  logic [LEN_W-1:0]   cur_len   = '0;
  logic [RETRY_W-1:0] retries   = '0;
  logic [TICK_W-1:0]  ticks     = '0;
  logic [PHASE_W-1:0] ph        = PHASE_IDLE;

  result_t step_pkt;             // packet being built by the current event
  result_t expected_pkts[$];     // packets the block still owes us
  sender_event_t event_backlog[$];

  int n_events = 0, n_data = 0, n_resend = 0, n_error = 0, n_matched = 0;
  int mismatches = 0;

  // offset of a block's payload: ((blk - 1) mod 2^16) * BLOCK_BYTES
  function automatic logic [OFF_W-1:0] offset_of(input logic [BLK_W-1:0] blk);
    logic [BLK_W-1:0] idx;
    idx = blk - 1'b1;
    return OFF_W'(int'(idx) * BLOCK_BYTES);
  endfunction

  function automatic logic [LEN_W-1:0] len_of(input logic [BLK_W-1:0] blk);
    logic [OFF_W-1:0] off, rem;
    off = offset_of(blk);
    if (fsize_cfg <= off) return '0;
    rem = fsize_cfg - off;
    return (rem < OFF_W'(BLOCK_BYTES)) ? LEN_W'(rem) : LEN_W'(BLOCK_BYTES);
  endfunction

  function automatic void load_data(input logic rexmit);
    step_pkt.send_kind    = KIND_DATA;
    step_pkt.block_number = cur_blk;
    step_pkt.byte_offset  = offset_of(cur_blk);
    step_pkt.payload_len  = cur_len;
    step_pkt.retransmit   = rexmit;
    n_data++;
    if (rexmit) n_resend++;
  endfunction

  function automatic void open_block(input logic [BLK_W-1:0] blk);
    cur_blk = blk;
    cur_len = len_of(blk);
    retries = '0;
    ticks   = '0;
    ph      = PHASE_WAIT;
    load_data(1'b0);
  endfunction

  // Advance the sender by one event and queue the packet it must emit.
  function automatic void sender_step(input sender_event_t ev);
    step_pkt = '0;
    case (ev.op)
      OP_START: begin
        if (ph == PHASE_IDLE) begin
          if (!ev.open_ok) begin
            step_pkt.send_kind = KIND_ERROR;
            ph = PHASE_FAIL;
            n_error++;
          end else begin
            acked_blk = '0;
            open_block(16'd1);
          end
        end
      end
      OP_ACK: begin
        // any ack clears the retry count; only the current block counts as acked
        if (ph == PHASE_WAIT) begin
          retries = '0;
          if (ev.ack_block == cur_blk) begin
            acked_blk = ev.ack_block;
            step_pkt.ack_matched = 1'b1;
            n_matched++;
          end
        end
      end
      OP_TICK: begin
        if (ph == PHASE_WAIT) begin
          if (ticks != '1) ticks = ticks + 1'b1;
          if (retries >= retry_limit) begin
            ph = PHASE_FAIL;
          end else if (acked_blk == cur_blk) begin
            if (cur_len < LEN_W'(BLOCK_BYTES)) ph = PHASE_DONE;
            else open_block(cur_blk + 1'b1);
          end else if (ticks >= tick_limit) begin
            if (retries != '1) retries = retries + 1'b1;
            ticks = '0;
            load_data(1'b1);
          end
        end
      end
      default: ;   // reserved op: no effect
    endcase
    step_pkt.phase = ph;
    expected_pkts.push_back(step_pkt);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops events from the backlog, idles at random unless steady_flow.
  // The predictor runs at the edge where the input transfer completes.
  // ---------------------------------------------------------------------------
  logic steady_flow = 1'b0;
  sender_event_t drv_ev;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        sender_step(drv_ev);
        n_events++;
      end
      if (!in_tvalid || in_tready) begin
        if (event_backlog.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 32)) begin
          drv_ev = event_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {7'd0, drv_ev.ack_block, drv_ev.open_ok};
          in_tuser  <= drv_ev.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: backpressure at random unless steady_flow, compare each result transfer with the
  // oldest expected packet.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_pkts.size() == 0) begin
          $error("result transfer with no packet expected");
          mismatches++;
        end else begin
          want = expected_pkts.pop_front();
          check_field("send_kind",    want.send_kind,    out_tuser);
          check_field("block_number", want.block_number, out_tdata[15:0]);
          check_field("byte_offset",  want.byte_offset,  out_tdata[40:16]);
          check_field("payload_len",  want.payload_len,  out_tdata[50:41]);
          check_field("retransmit",   want.retransmit,   out_tdata[51]);
          check_field("ack_matched",  want.ack_matched,  out_tdata[52]);
          check_field("phase",        want.phase,        out_tdata[54:53]);
        end
      end
      out_tready <= steady_flow || $urandom_range(0, 99) >= 32;
    end
  end

  // Watchdog: nothing moving on either channel for too long means a hang.
  int stall_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation. gen_block tracks the block the sender should be on;
  // quiet_ticks bounds the retry count so random noise never fails the
  // transfer before the planned ending.
  // ---------------------------------------------------------------------------
  logic [BLK_W-1:0] gen_block = '0;
  int quiet_ticks = 0;
  int counted = 0;   // ticks and acks, i.e. events the block acts on

  function automatic void push_event(input logic [OP_W-1:0] op, input logic ok,
                                     input logic [BLK_W-1:0] ack);
    sender_event_t ev;
    ev.op = op;
    ev.open_ok = ok;
    ev.ack_block = ack;
    event_backlog.push_back(ev);
  endfunction

  function automatic logic [BLK_W-1:0] wrong_ack();
    logic [BLK_W-1:0] v;
    v = $urandom_range(0, 1) ? gen_block - 1'b1 : BLK_W'($urandom);   // stale dup or noise
    if (v == gen_block) v = v ^ 16'h8000;
    return v;
  endfunction

  // one block's round: some noise, then usually ack + tick to move on
  function automatic void queue_round();
    int n_noise, pick;
    n_noise = $urandom_range(0, 3);
    for (int i = 0; i < n_noise; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5 && quiet_ticks < int'(retry_limit)) begin
        push_event(OP_TICK, 1'($urandom), BLK_W'($urandom));
        quiet_ticks++;
        counted++;
      end else if (pick < 8) begin
        push_event(OP_ACK, 1'($urandom), wrong_ack());
        quiet_ticks = 0;
        counted++;
      end else if (pick == 8) begin
        push_event(OP_START, 1'($urandom), BLK_W'($urandom));
      end else begin
        push_event(OP_RSVD, 1'($urandom), BLK_W'($urandom));
      end
    end
    if ($urandom_range(0, 99) < 85) begin
      push_event(OP_ACK, 1'($urandom), gen_block);
      counted++;
      if ($urandom_range(0, 4) == 0) begin
        push_event(OP_ACK, 1'($urandom), wrong_ack());
        counted++;
      end
      push_event(OP_TICK, 1'($urandom), BLK_W'($urandom));
      counted++;
      gen_block = gen_block + 1'b1;
      quiet_ticks = 0;
    end
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FILE_SIZE:     fsize_cfg   = val;
      REG_MAX_RETRIES:   retry_limit = val[RETRY_W-1:0];
      REG_TIMEOUT_TICKS: tick_limit  = val[TICK_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every event is in and every packet is out, then let the block settle
  task automatic drain();
    while (event_backlog.size() != 0 || in_tvalid || expected_pkts.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
    gen_block = cur_blk;
    quiet_ticks = int'(retries);
  endtask

  initial begin
    int sel, m, phase_goal;
    logic [CFG_DATA_W-1:0] fsz;
    logic end_in_fail;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: events while idle are ignored, reserved op too.
    push_event(OP_TICK, 1'b1, 16'hFFFF);
    push_event(OP_ACK,  1'b0, 16'hFFFF);
    push_event(OP_RSVD, 1'b1, 16'hFFFF);
    push_event(OP_ACK,  1'b1, 16'h0000);
    drain();

    write_reg(REG_FILE_SIZE, '0);
    write_reg(REG_FILE_SIZE, FILE_SIZE_MAX);
    write_reg(REG_MAX_RETRIES, 25'd255);
    write_reg(REG_TIMEOUT_TICKS, 25'd1);

    // Start, second start ignored, two timeout resends, wrong acks clear
    // the retries, then two blocks acked and advanced.
    push_event(OP_START, 1'b1, 16'h0000);
    push_event(OP_START, 1'b0, 16'hFFFF);
    push_event(OP_TICK,  1'b0, 16'h0000);
    push_event(OP_TICK,  1'b1, 16'hFFFF);
    push_event(OP_ACK,   1'b0, 16'h0000);
    push_event(OP_ACK,   1'b1, 16'hFFFF);
    push_event(OP_ACK,   1'b0, 16'd1);
    push_event(OP_TICK,  1'b0, 16'h0000);
    push_event(OP_ACK,   1'b1, 16'd2);
    push_event(OP_TICK,  1'b1, 16'h0000);
    drain();

    // Longest timeout: ticks pass with no resend; stale ack after the match.
    write_reg(REG_TIMEOUT_TICKS, 25'd65535);
    write_reg(REG_MAX_RETRIES, 25'd1);
    push_event(OP_TICK, 1'b0, 16'h5555);
    push_event(OP_TICK, 1'b1, 16'hAAAA);
    push_event(OP_ACK,  1'b0, 16'd3);
    push_event(OP_ACK,  1'b1, 16'd2);
    push_event(OP_TICK, 1'b0, 16'h0000);
    drain();

    // Zero timeout: every unacked tick resends.
    write_reg(REG_TIMEOUT_TICKS, '0);
    write_reg(REG_MAX_RETRIES, 25'd3);
    push_event(OP_TICK, 1'b1, 16'h0000);
    push_event(OP_TICK, 1'b0, 16'h0000);
    push_event(OP_ACK,  1'b1, 16'd4);
    push_event(OP_TICK, 1'b0, 16'h0000);

    // Random phases, new settings between them; one phase with no idling.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      steady_flow = (p == 2);
      fsz = (p == 3) ? FILE_SIZE_MAX
          : CFG_DATA_W'($urandom_range(int'(FILE_SIZE_MAX), (int'(gen_block) + 400) * 512));
      sel = $urandom_range(0, 2);
      write_reg(REG_MAX_RETRIES, (sel == 0) ? CFG_DATA_W'(255)
        : (sel == 1) ? CFG_DATA_W'($urandom_range(1, 4)) : CFG_DATA_W'($urandom_range(5, 254)));
      sel = $urandom_range(0, 3);
      write_reg(REG_TIMEOUT_TICKS, (sel == 0) ? CFG_DATA_W'(0)
        : (sel == 1) ? CFG_DATA_W'(1)
        : (sel == 2) ? CFG_DATA_W'($urandom_range(2, 6)) : CFG_DATA_W'($urandom_range(7, 40)));
      write_reg(REG_FILE_SIZE, fsz);
      phase_goal = counted + EVENTS_PER_PHASE;
      while (counted < phase_goal) queue_round();
    end

    drain();
    steady_flow = 1'b0;
    end_in_fail = 1'($urandom);
    if (end_in_fail) begin
      // Retries run out: a wrong ack zeroes them, then m resends and the failing tick.
      m = $urandom_range(0, 3);
      write_reg(REG_MAX_RETRIES, CFG_DATA_W'(m));
      write_reg(REG_TIMEOUT_TICKS, 25'd1);
      push_event(OP_ACK, 1'b0, gen_block ^ 16'h8000);
      for (int i = 0; i <= m; i++) push_event(OP_TICK, 1'($urandom), BLK_W'($urandom));
    end else begin
      // File ends at the next block: empty, remainder, or zero-size file.
      sel = $urandom_range(0, 2);
      fsz = (sel == 0) ? '0 : CFG_DATA_W'(int'(gen_block) * BLOCK_BYTES);
      if (sel == 2) fsz = fsz + CFG_DATA_W'($urandom_range(1, BLOCK_BYTES - 1));
      write_reg(REG_FILE_SIZE, fsz);
      push_event(OP_ACK,  1'b1, gen_block);
      push_event(OP_TICK, 1'b0, 16'h0000);
      push_event(OP_TICK, 1'b1, 16'h0000);
      push_event(OP_ACK,  1'b0, gen_block + 1'b1);
      push_event(OP_TICK, 1'b1, 16'hFFFF);
    end
    // Once finished or failed, everything is ignored, a fresh start included.
    push_event(OP_TICK,  1'b1, 16'h0000);
    push_event(OP_ACK,   1'b0, cur_blk);
    push_event(OP_START, 1'b1, 16'h0000);
    push_event(OP_START, 1'b0, 16'hFFFF);
    push_event(OP_RSVD,  1'b0, 16'h0000);

    drain();
    repeat (8) @(posedge clk);

    $display("Ran %0d events: %0d data packets (%0d timeout resends), %0d error packets,",
             n_events, n_data, n_resend, n_error);
    $display("%0d matching acks; transfer stopped at block %0d in phase %0d",
             n_matched, cur_blk, ph);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
